### sv/fta_pkg.sv
// ---------------------------------------------------------------------------
// fta_pkg: shared types and constants for the token admission arbiter
// Sizes of the holder set and the wait queue, opcode and state encodings,
// and the command and status bundles between controller and datapath.
// ---------------------------------------------------------------------------
package fta_pkg;

   // Storage sizes
   localparam int ACTIVE_SLOTS = 8;
   localparam int QUEUE_DEPTH  = 16;
   localparam int ID_BITS      = 6;

   // Derived widths
   localparam int SLOT_IDX_W = (ACTIVE_SLOTS > 1) ? $clog2(ACTIVE_SLOTS) : 1;
   localparam int CNT_W      = $clog2(ACTIVE_SLOTS + 1);
   localparam int QIDX_W     = $clog2(QUEUE_DEPTH);
   localparam int QLEN_W     = $clog2(QUEUE_DEPTH + 1);
   localparam int CFG_W      = 4;
   localparam int CMP_W      = (CNT_W > CFG_W) ? CNT_W : CFG_W;

   // Fixed field widths of the stream words
   localparam int ACT_FIELD_W  = 4;
   localparam int WAIT_FIELD_W = 5;
   localparam int REQ_DATA_W   = 8;
   localparam int RSP_DATA_W   = 16;

   localparam logic [CFG_W-1:0] MAX_CONCURRENT_RESET = CFG_W'(2);

   typedef enum logic {
      OP_REQUEST = 1'b0,
      OP_RELEASE = 1'b1
   } fta_op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_COMMIT
   } fta_state_type;

   // Controller to datapath
   typedef struct packed {
      logic capture;
      logic lookup;
      logic commit;
   } fta_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic out_busy;
   } fta_status_type;

endpackage

### sv/fifo_token_admission_arbiter_top.sv
// ---------------------------------------------------------------------------
// fifo_token_admission_arbiter_top: counting semaphore with FIFO fairness
// Each word goes through capture, a parallel search of the eight
// holder slots and sixteen queue entries, and a commit that grants, queues
// or releases and loads the result register. A new word is taken once the
// previous one has committed; the commit waits while an earlier result has
// not yet been taken at the output, so one result can wait there while the
// next word is searched. csr_we writes max_concurrent (reset value 2; zero
// acts as one) and must only be used while no word is in flight.
// ---------------------------------------------------------------------------
module fifo_token_admission_arbiter_top
   import fta_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CFG_W-1:0]      csr_wdata,    // max_concurrent
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,    // [5:0] requester_id, rest zero
   input  logic                  req_tuser,    // [0] opcode: 0 request, 1 release
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata     // [0] granted, [4:1] active_count,
                                               // [9:5] waiting_count,
                                               // [10] queue_overflow, rest zero
);

   fta_cmd_type    cmd;
   fta_status_type status;

   // Sequencer
   fta_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // Holder set, queue and result
   fta_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // One word in flight at a time
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("input taken again while a word is in flight");

   // A grant and an overflow never come together
   a_grant_xor_overflow: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[0] && rsp_tdata[10]))
      else $error("result both granted and overflowed");

   // Holder and queue counts stay within their storage
   a_counts_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((rsp_tdata[4:1] <= ACT_FIELD_W'(ACTIVE_SLOTS))
                      && (rsp_tdata[9:5] <= WAIT_FIELD_W'(QUEUE_DEPTH))))
      else $error("holder or queue count out of range");

   // A result appears only after the commit of an accepted word
   a_result_after_commit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(cmd.commit))
      else $error("result without a commit");

endmodule

### sv/fta_ctrl.sv
// ---------------------------------------------------------------------------
// fta_ctrl: sequencer for the token admission arbiter
// Steps each accepted word through capture, lookup and commit, and holds
// the commit while the previous result still waits at the output.
// ---------------------------------------------------------------------------
module fta_ctrl
   import fta_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_tvalid,
   output logic           req_tready,
   input  fta_status_type status,
   output fta_cmd_type    cmd
);

   fta_state_type state_ff;
   fta_state_type state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in    = state_ff;
      req_tready  = 1'b0;
      cmd.capture = 1'b0;
      cmd.lookup  = 1'b0;
      cmd.commit  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            cmd.lookup = 1'b1;
            state_in   = ST_COMMIT;
         end
         ST_COMMIT: begin
            if (!status.out_busy) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

### sv/fta_datapath.sv
// ---------------------------------------------------------------------------
// fta_datapath: holder set, wait queue and result register
// Searches the holder slots and the queue for the captured id, then applies
// the grant, enqueue or release and loads the result word.
// ---------------------------------------------------------------------------
module fta_datapath
   import fta_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  fta_cmd_type           cmd,
   output fta_status_type        status,
   input  logic                  csr_we,
   input  logic [CFG_W-1:0]      csr_wdata,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   // Captured word
   fta_op_type           op_ff;
   logic [ID_BITS-1:0]   id_ff;

   // Holder set and wait queue
   logic [ID_BITS-1:0]      holder_id_ff [ACTIVE_SLOTS];
   logic [ACTIVE_SLOTS-1:0] holder_valid_ff;
   logic [ID_BITS-1:0]      queue_ff [QUEUE_DEPTH];
   logic [QLEN_W-1:0]       qlen_ff;
   logic [CFG_W-1:0]        max_concurrent_ff;

   // Lookup results
   logic [ACTIVE_SLOTS-1:0] hit_mask_ff, hit_mask_in;
   logic                    queued_ff, queued_in;
   logic [QIDX_W-1:0]       qpos_ff, qpos_in;
   logic [CNT_W-1:0]        hcount_ff, hcount_in;
   logic [SLOT_IDX_W-1:0]   free_idx_ff, free_idx_in;

   // Result register
   logic                    rsp_valid_ff;
   logic [RSP_DATA_W-1:0]   rsp_data_ff, rsp_data_in;

   // Commit decisions
   logic              is_release;
   logic              holder_hit;
   logic              limit_ok;
   logic              slot_ok;
   logic              head_match;
   logic              overflow;
   logic              grant_new;
   logic              granted;
   logic              do_remove;
   logic              do_append;
   logic              release_slot;
   logic [CMP_W-1:0]  limit;
   logic [CNT_W-1:0]  hcount_new;
   logic [QLEN_W-1:0] qlen_new;

   assign status.out_busy = rsp_valid_ff && !rsp_tready;
   assign rsp_tvalid      = rsp_valid_ff;
   assign rsp_tdata       = rsp_data_ff;

   // Configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         max_concurrent_ff <= MAX_CONCURRENT_RESET;
      end else if (csr_we) begin
         max_concurrent_ff <= csr_wdata;
      end
   end

   // Capture the incoming word
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff <= fta_op_type'(req_tuser);
         id_ff <= req_tdata[ID_BITS-1:0];
      end
   end

   // Search holder slots and queue entries in parallel
   always_comb begin
      queued_in   = 1'b0;
      qpos_in     = '0;
      free_idx_in = '0;
      for (int i = 0; i < ACTIVE_SLOTS; i++) begin
         hit_mask_in[i] = holder_valid_ff[i] && (holder_id_ff[i] == id_ff);
      end
      for (int i = QUEUE_DEPTH - 1; i >= 0; i--) begin
         if ((QLEN_W'(i) < qlen_ff) && (queue_ff[i] == id_ff)) begin
            queued_in = 1'b1;
            qpos_in   = QIDX_W'(i);
         end
      end
      for (int i = ACTIVE_SLOTS - 1; i >= 0; i--) begin
         if (!holder_valid_ff[i]) begin
            free_idx_in = SLOT_IDX_W'(i);
         end
      end
      hcount_in = CNT_W'($countones(holder_valid_ff));
   end

   always_ff @(posedge clock) begin
      if (cmd.lookup) begin
         hit_mask_ff <= hit_mask_in;
         queued_ff   <= queued_in;
         qpos_ff     <= qpos_in;
         hcount_ff   <= hcount_in;
         free_idx_ff <= free_idx_in;
      end
   end

   // Decide the outcome from the lookup
   always_comb begin
      is_release   = (op_ff == OP_RELEASE);
      holder_hit   = |hit_mask_ff;
      limit        = (max_concurrent_ff == '0) ? CMP_W'(1) : CMP_W'(max_concurrent_ff);
      limit_ok     = CMP_W'(hcount_ff) < limit;
      slot_ok      = hcount_ff < CNT_W'(ACTIVE_SLOTS);
      head_match   = queued_ff ? (qpos_ff == '0) : (qlen_ff == '0);
      overflow     = !is_release && !holder_hit && !queued_ff
                     && (qlen_ff == QLEN_W'(QUEUE_DEPTH));
      grant_new    = !is_release && !holder_hit && !overflow
                     && head_match && limit_ok && slot_ok;
      granted      = (!is_release && holder_hit) || grant_new;
      do_remove    = queued_ff && (is_release || grant_new);
      do_append    = !is_release && !holder_hit && !overflow && !queued_ff && !grant_new;
      release_slot = is_release && holder_hit;
      hcount_new   = hcount_ff + CNT_W'(grant_new) - CNT_W'(release_slot);
      qlen_new     = qlen_ff - QLEN_W'(do_remove) + QLEN_W'(do_append);
      rsp_data_in  = '0;
      rsp_data_in[0]                       = granted;
      rsp_data_in[ACT_FIELD_W:1]           = ACT_FIELD_W'(hcount_new);
      rsp_data_in[ACT_FIELD_W+WAIT_FIELD_W:ACT_FIELD_W+1] = WAIT_FIELD_W'(qlen_new);
      rsp_data_in[ACT_FIELD_W+WAIT_FIELD_W+1]             = overflow;
   end

   // Update holder valid bits and queue length
   always_ff @(posedge clock) begin
      if (reset) begin
         holder_valid_ff <= '0;
         qlen_ff         <= '0;
      end else if (cmd.commit) begin
         qlen_ff <= qlen_new;
         if (release_slot) begin
            holder_valid_ff <= holder_valid_ff & ~hit_mask_ff;
         end else if (grant_new) begin
            holder_valid_ff[free_idx_ff] <= 1'b1;
         end
      end
   end

   // Update holder ids
   always_ff @(posedge clock) begin
      if (cmd.commit && grant_new) begin
         holder_id_ff[free_idx_ff] <= id_ff;
      end
   end

   // Compact the queue on removal, append at the tail otherwise
   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         for (int i = 0; i < QUEUE_DEPTH; i++) begin
            if (do_remove && (QIDX_W'(i) >= qpos_ff) && (i < QUEUE_DEPTH - 1)) begin
               queue_ff[i] <= queue_ff[QIDX_W'(i + 1)];
            end else if (do_append && (QLEN_W'(i) == qlen_ff)) begin
               queue_ff[i] <= id_ff;
            end
         end
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule
